### hdl/bwlp_pkg.sv
// Package for the tenth-order Butterworth low-pass IIR block.
// Holds widths, the fixed-point coefficient tables and the MAC control types.
// No dependencies; used by bwlp_mac and butterworth_iir_lowpass_top.
package bwlp_pkg;

  // Data formats.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 40;
  localparam int OUT_BITS    = 24;
  localparam int Y_BITS      = 64;
  localparam int ACC_BITS    = 128;
  localparam int GAIN_SHIFT  = 56;

  // Filter shape.
  localparam int NTAPS       = 11;
  localparam int NFB         = 10;
  localparam int PRIME_COUNT = 11;
  localparam int FB_PARTS    = 4;

  // Shared multiplier: 33x33 signed, registered 66-bit product.
  localparam int OP_BITS     = 33;
  localparam int PROD_BITS   = 2 * OP_BITS;
  localparam int HALF_BITS   = Y_BITS / 2;
  // The binomial sum of eleven samples is held in 27 signed bits.
  localparam int SUM_BITS    = SAMPLE_BITS + 11;
  localparam int BINOM_BITS  = 9;

  // Binomial weights of the feedforward part.
  localparam logic [BINOM_BITS-1:0] BINOM [NTAPS] = '{
    9'd1, 9'd10, 9'd45, 9'd120, 9'd210, 9'd252, 9'd210, 9'd120, 9'd45, 9'd10, 9'd1
  };

  // Reciprocal of the gain 2.762663641e8, scaled by 2^56, rounded.
  localparam logic [127:0] GAIN_X10    = 128'd2762663641;
  localparam logic [127:0] INV_GAIN_W  =
    ((128'd10 << GAIN_SHIFT) + (GAIN_X10 >> 1)) / GAIN_X10;
  localparam logic [HALF_BITS-1:0] INV_GAIN = INV_GAIN_W[HALF_BITS-1:0];

  // Feedback coefficients: magnitudes in units of 1e-10, oldest output first.
  localparam logic [127:0] DEC_SCALE = 128'd10000000000;
  localparam logic [63:0] FB_MAG [NFB] = '{
    64'd1327680842,   64'd15942397677,  64'd86456821375,  64'd278902991720,
    64'd592809515740, 64'd867670680410, 64'd885876632510, 64'd623153522820,
    64'd289121945840, 64'd79922966624
  };
  // Set where the coefficient is negative.
  localparam logic [NFB-1:0] FB_NEG = 10'b01_0101_0101;

  typedef logic signed [Y_BITS-1:0] fb_coef_arr_t [NFB];

  // Converts the decimal coefficients to Q(FRAC_BITS), rounding half away.
  function automatic fb_coef_arr_t build_fb_coef();
    fb_coef_arr_t c;
    logic [127:0] q;
    for (int k = 0; k < NFB; k++) begin
      q = ((128'(FB_MAG[k]) << FRAC_BITS) + (DEC_SCALE >> 1)) / DEC_SCALE;
      c[k] = FB_NEG[k] ? -$signed(q[Y_BITS-1:0]) : $signed(q[Y_BITS-1:0]);
    end
    return c;
  endfunction

  localparam fb_coef_arr_t FB_COEF = build_fb_coef();

  // Left shift applied to a partial product before accumulation.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_GAIN,
    SH_WORD,
    SH_DWORD
  } pp_shift_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic      issue;
    logic      clear;
    pp_shift_t shift;
  } mac_ctl_t;

endpackage

### hdl/bwlp_mac.sv
// Shared multiply-accumulate unit of the Butterworth low-pass block.
// One 33x33 signed product per cycle, registered, then shifted into a 128-bit accumulator.
// Depends on bwlp_pkg.
module bwlp_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bwlp_pkg::mac_ctl_t                     ctl,
  input  logic signed [bwlp_pkg::OP_BITS-1:0]    op_a,
  input  logic signed [bwlp_pkg::OP_BITS-1:0]    op_b,
  output logic signed [bwlp_pkg::ACC_BITS-1:0]   acc
);
  import bwlp_pkg::*;

  logic signed [PROD_BITS-1:0] prod;
  logic                        prod_valid;
  pp_shift_t                   prod_shift;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  addend;

  // Sign-extend the product and align it to its weight.
  always_comb begin
    prod_ext = ACC_BITS'(prod);
    case (prod_shift)
      SH_NONE:  addend = prod_ext;
      SH_GAIN:  addend = prod_ext <<< (2 * FRAC_BITS - GAIN_SHIFT);
      SH_WORD:  addend = prod_ext <<< HALF_BITS;
      SH_DWORD: addend = prod_ext <<< Y_BITS;
      default:  addend = prod_ext;
    endcase
  end

  // Product valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.issue;
    end
  end

  // Product register and accumulator; the sequencer clears before use.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod       <= op_a * op_b;
      prod_shift <= ctl.shift;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + addend;
    end
  end

endmodule

### hdl/butterworth_iir_lowpass_top.sv
// Top level of the tenth-order Butterworth low-pass IIR filter.
// Holds the sequencer, the sample and output histories and the output register.
// Depends on bwlp_pkg and bwlp_mac.
//
// Usage:
//   Samples enter on the s_axis channel, one signed 16-bit sample per transaction.
//   Each sample gives exactly one result transaction on the m_axis channel:
//   m_axis_tdata carries the Q16.8 filtered value, m_axis_tuser the primed flag.
//   Until eleven samples have arrived the result is zero with primed clear.
// Sequence:
//   For a primed sample, between acceptance and the next acceptance, one
//   shared 33x33 multiplier does 11 binomial products, one gain product and
//   four partial products for each of the ten feedback taps, one per cycle,
//   plus pipeline drain, rounding, scaling and hand-off. An unprimed sample
//   goes straight to hand-off. s_axis_tready is high only while the sequencer is idle.
// Reset (rst, synchronous, active high) clears both histories, the fill count
// and the output valid. When the receiver stalls, the finished result waits in
// its own register while the next sample is taken; the following result waits
// for that register to empty before the block accepts again.
module butterworth_iir_lowpass_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample [15:0]
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // filtered [23:0]
  output logic signed [bwlp_pkg::OUT_BITS-1:0]  m_axis_tdata,
  // primed [0]
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready
);
  import bwlp_pkg::*;

  localparam int STEP_BITS = 6;
  localparam int CNT_BITS  = 4;
  localparam int TAP_BITS  = 4;
  localparam int Q_BITS    = Y_BITS - (FRAC_BITS - 8) + 1;
  localparam logic signed [Q_BITS-1:0] F_MAX = Q_BITS'((1 <<< (OUT_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] F_MIN = -Q_BITS'(1 <<< (OUT_BITS - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_FF,
    S_FF_WAIT,
    S_GAIN,
    S_FB,
    S_FB_WAIT,
    S_ROUND,
    S_SCALE,
    S_DONE
  } state_t;

  state_t                      state;
  logic [STEP_BITS-1:0]        step;
  logic [CNT_BITS-1:0]         fill_count;
  logic [CNT_BITS-1:0]         fill_next;
  logic signed [SAMPLE_BITS-1:0] sample_hist [NTAPS];
  logic signed [Y_BITS-1:0]    out_hist [NFB];
  logic signed [OUT_BITS-1:0]  res_filtered;
  logic                        res_primed;
  logic                        s_accept;

  mac_ctl_t                    mac_ctl;
  logic signed [OP_BITS-1:0]   op_a;
  logic signed [OP_BITS-1:0]   op_b;
  logic signed [ACC_BITS-1:0]  acc;

  logic [TAP_BITS-1:0]         tap;
  logic [1:0]                  part;
  logic signed [Y_BITS-1:0]    coef;
  logic signed [Y_BITS-1:0]    yv;
  logic signed [SUM_BITS-1:0]  s_sum;

  logic signed [ACC_BITS-1:0]  acc_rnd;
  logic signed [ACC_BITS-1:0]  acc_shr;
  logic signed [Y_BITS-1:0]    y_sat;
  logic signed [Q_BITS-1:0]    q_wide;
  logic signed [OUT_BITS-1:0]  f_sat;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign fill_next     = (fill_count == CNT_BITS'(PRIME_COUNT)) ? fill_count
                                                                : fill_count + 1'b1;

  // Operand selection for the shared multiplier.
  always_comb begin
    tap     = step[STEP_BITS-1:2];
    part    = step[1:0];
    coef    = FB_COEF[tap];
    yv      = out_hist[tap];
    s_sum   = acc[SUM_BITS-1:0];
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    case (state)
      S_IDLE: begin
        mac_ctl.clear = s_accept;
      end
      S_FF: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = SH_NONE;
        op_a = {{(OP_BITS - BINOM_BITS){1'b0}}, BINOM[step[TAP_BITS-1:0]]};
        op_b = OP_BITS'(sample_hist[step[TAP_BITS-1:0]]);
      end
      S_GAIN: begin
        // The binomial sum is complete; restart the accumulator with its gain product.
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_ctl.shift = SH_GAIN;
        op_a = OP_BITS'(s_sum);
        op_b = {1'b0, INV_GAIN};
      end
      S_FB: begin
        // Four partial products per tap: low halves unsigned, high halves signed.
        mac_ctl.issue = 1'b1;
        op_a = part[1] ? OP_BITS'($signed(coef[Y_BITS-1:HALF_BITS]))
                       : {1'b0, coef[HALF_BITS-1:0]};
        op_b = part[0] ? OP_BITS'($signed(yv[Y_BITS-1:HALF_BITS]))
                       : {1'b0, yv[HALF_BITS-1:0]};
        case (part)
          2'd0:    mac_ctl.shift = SH_NONE;
          2'd3:    mac_ctl.shift = SH_DWORD;
          default: mac_ctl.shift = SH_WORD;
        endcase
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  bwlp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // Round to FRAC_BITS and saturate to 64 bits.
  always_comb begin
    acc_rnd = acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
    acc_shr = acc_rnd >>> FRAC_BITS;
    if ((&acc_shr[ACC_BITS-1:Y_BITS-1]) || !(|acc_shr[ACC_BITS-1:Y_BITS-1])) begin
      y_sat = acc_shr[Y_BITS-1:0];
    end else if (acc_shr[ACC_BITS-1]) begin
      y_sat = {1'b1, {(Y_BITS - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_BITS - 1){1'b1}}};
    end
  end

  // Scale the newest output to Q16.8, round half up, saturate to 24 bits.
  always_comb begin
    q_wide = Q_BITS'($signed(out_hist[NFB-1][Y_BITS-1:FRAC_BITS-8]))
           + Q_BITS'({1'b0, out_hist[NFB-1][FRAC_BITS-9]});
    if (q_wide > F_MAX) begin
      f_sat = F_MAX[OUT_BITS-1:0];
    end else if (q_wide < F_MIN) begin
      f_sat = F_MIN[OUT_BITS-1:0];
    end else begin
      f_sat = q_wide[OUT_BITS-1:0];
    end
  end

  // Sample and output histories, oldest entry first.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NTAPS; i++) sample_hist[i] <= '0;
      for (int i = 0; i < NFB; i++) out_hist[i] <= '0;
    end else begin
      if (s_accept) begin
        for (int i = 0; i < NTAPS - 1; i++) sample_hist[i] <= sample_hist[i + 1];
        sample_hist[NTAPS-1] <= s_axis_tdata;
      end
      if (state == S_ROUND) begin
        for (int i = 0; i < NFB - 1; i++) out_hist[i] <= out_hist[i + 1];
        out_hist[NFB-1] <= y_sat;
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      fill_count    <= '0;
      res_filtered  <= '0;
      res_primed    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            fill_count <= fill_next;
            step       <= '0;
            if (fill_next == CNT_BITS'(PRIME_COUNT)) begin
              state <= S_FF;
            end else begin
              res_filtered <= '0;
              res_primed   <= 1'b0;
              state        <= S_DONE;
            end
          end
        end
        S_FF: begin
          step <= step + 1'b1;
          if (step == STEP_BITS'(NTAPS - 1)) begin
            state <= S_FF_WAIT;
          end
        end
        S_FF_WAIT: begin
          state <= S_GAIN;
        end
        S_GAIN: begin
          step  <= '0;
          state <= S_FB;
        end
        S_FB: begin
          step <= step + 1'b1;
          if (step == STEP_BITS'(FB_PARTS * NFB - 1)) begin
            state <= S_FB_WAIT;
          end
        end
        S_FB_WAIT: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          res_filtered <= f_sat;
          res_primed   <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_filtered;
            m_axis_tuser  <= res_primed;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count saturates at the priming threshold.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_BITS'(PRIME_COUNT))
    else $error("fill count beyond priming threshold");

  // A primed result can only follow a full sample history.
  a_primed_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> fill_count == CNT_BITS'(PRIME_COUNT))
    else $error("primed result before eleven samples");

  // An unprimed result carries zero.
  a_unprimed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero result while not primed");

  // One sample at a time: the sequencer leaves idle after each acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_axis_tready)
    else $error("second sample accepted while busy");

endmodule
